// ===== src/aep_pkg.sv =====
// aep_pkg: shared widths, fixed-point constants and the arctangent table function
// for the azimuthal equidistant projection. No dependencies.

package aep_pkg;

	// CORDIC depth and step index width
	localparam int CORDIC_STEPS = 32;
	localparam int STEP_W = $clog2(CORDIC_STEPS);

	// datapath widths: Q.32 values in DW bits, multiplier operand magnitudes in MW bits
	localparam int DW = 40;
	localparam int MW = 36;
	localparam int OW = 36;

	// configuration register indexes
	localparam int CFG_AW = 1;
	localparam logic [CFG_AW-1:0] REG_REF_LAT = 1'b0;
	localparam logic [CFG_AW-1:0] REG_REF_LON = 1'b1;

	localparam logic [63:0] PI60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] PI_Q_64 = (PI60 + 64'd134217728) >> 28;
	localparam logic [63:0] HALF_PI_Q_64 = (PI60 + 64'd268435456) >> 29;
	localparam logic signed [DW-1:0] PI_Q = PI_Q_64[DW-1:0];
	localparam logic signed [DW-1:0] HALF_PI_Q = HALF_PI_Q_64[DW-1:0];
	localparam logic signed [DW-1:0] ONE_Q = {{(DW-33){1'b0}}, 1'b1, 32'd0};
	localparam logic signed [DW-1:0] GAIN_Q = {{(DW-32){1'b0}}, 32'h9B74EDA8};

	// degrees * 1e7 to Q.32 radians, applied to the magnitude
	localparam logic [63:0] DEG_COEF_64 = (64'd2 * PI60 + 64'd900000000) / 64'd1800000000;
	localparam logic [31:0] DEG_COEF = DEG_COEF_64[31:0];

	localparam logic signed [32:0] HALF_TURN_E7 = 33'sd1800000000;
	localparam logic signed [32:0] FULL_TURN_E7 = 33'sd3600000000;

	localparam logic [63:0] RADIUS_64 = 64'd6371000000;
	localparam logic [63:0] OUT_LIM_64 = 64'd20015087000;
	localparam logic signed [DW-1:0] RADIUS_MM = RADIUS_64[DW-1:0];
	localparam logic signed [DW-1:0] OUT_LIM = OUT_LIM_64[DW-1:0];

	// round(atan(2^-i) * 2^32) from the alternating series at 60 fraction bits
	function automatic logic signed [DW-1:0] atan_entry(input int i);
		logic [63:0] v;
		logic [63:0] r;
		v = '0;
		if (i == 0) begin
			v = PI60 >> 2;
		end else begin
			if (i <= 60) v = v + (64'd1 << (60 - i));
			if (3 * i <= 60) v = v - ((64'd1 << (60 - 3 * i)) / 64'd3);
			if (5 * i <= 60) v = v + ((64'd1 << (60 - 5 * i)) / 64'd5);
			if (7 * i <= 60) v = v - ((64'd1 << (60 - 7 * i)) / 64'd7);
			if (9 * i <= 60) v = v + ((64'd1 << (60 - 9 * i)) / 64'd9);
			if (11 * i <= 60) v = v - ((64'd1 << (60 - 11 * i)) / 64'd11);
			if (13 * i <= 60) v = v + ((64'd1 << (60 - 13 * i)) / 64'd13);
			if (15 * i <= 60) v = v - ((64'd1 << (60 - 15 * i)) / 64'd15);
			if (17 * i <= 60) v = v + ((64'd1 << (60 - 17 * i)) / 64'd17);
			if (19 * i <= 60) v = v - ((64'd1 << (60 - 19 * i)) / 64'd19);
			if (21 * i <= 60) v = v + ((64'd1 << (60 - 21 * i)) / 64'd21);
			if (23 * i <= 60) v = v - ((64'd1 << (60 - 23 * i)) / 64'd23);
			if (25 * i <= 60) v = v + ((64'd1 << (60 - 25 * i)) / 64'd25);
			if (27 * i <= 60) v = v - ((64'd1 << (60 - 27 * i)) / 64'd27);
			if (29 * i <= 60) v = v + ((64'd1 << (60 - 29 * i)) / 64'd29);
			if (31 * i <= 60) v = v - ((64'd1 << (60 - 31 * i)) / 64'd31);
			if (33 * i <= 60) v = v + ((64'd1 << (60 - 33 * i)) / 64'd33);
			if (35 * i <= 60) v = v - ((64'd1 << (60 - 35 * i)) / 64'd35);
			if (37 * i <= 60) v = v + ((64'd1 << (60 - 37 * i)) / 64'd37);
			if (39 * i <= 60) v = v - ((64'd1 << (60 - 39 * i)) / 64'd39);
			if (41 * i <= 60) v = v + ((64'd1 << (60 - 41 * i)) / 64'd41);
			if (43 * i <= 60) v = v - ((64'd1 << (60 - 43 * i)) / 64'd43);
			if (45 * i <= 60) v = v + ((64'd1 << (60 - 45 * i)) / 64'd45);
			if (47 * i <= 60) v = v - ((64'd1 << (60 - 47 * i)) / 64'd47);
			if (49 * i <= 60) v = v + ((64'd1 << (60 - 49 * i)) / 64'd49);
			if (51 * i <= 60) v = v - ((64'd1 << (60 - 51 * i)) / 64'd51);
			if (53 * i <= 60) v = v + ((64'd1 << (60 - 53 * i)) / 64'd53);
			if (55 * i <= 60) v = v - ((64'd1 << (60 - 55 * i)) / 64'd55);
			if (57 * i <= 60) v = v + ((64'd1 << (60 - 57 * i)) / 64'd57);
			if (59 * i <= 60) v = v - ((64'd1 << (60 - 59 * i)) / 64'd59);
		end
		r = (v + 64'd134217728) >> 28;
		return r[DW-1:0];
	endfunction

endpackage

// ===== src/aep_cordic_cell.sv =====
// aep_cordic_cell: one registered CORDIC micro-rotation, rotation or vectoring.
// Depends on aep_pkg.

module aep_cordic_cell
	import aep_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic                 vect,
	input  logic [STEP_W-1:0]    step,
	input  logic signed [DW-1:0] angle,
	input  logic signed [DW-1:0] x_prev,
	input  logic signed [DW-1:0] y_prev,
	input  logic signed [DW-1:0] z_prev,
	output logic signed [DW-1:0] x,
	output logic signed [DW-1:0] y,
	output logic signed [DW-1:0] z
);

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic                 cw;
	logic signed [DW-1:0] x_q;
	logic signed [DW-1:0] y_q;
	logic signed [DW-1:0] z_q;

	assign dx = y_prev >>> step;
	assign dy = x_prev >>> step;
	// vectoring drives y to zero, rotation drives z to zero
	assign cw = vect ? (!y_prev[DW-1] && (y_prev != '0)) : z_prev[DW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (cw) begin
				x_q <= x_prev + dx;
				y_q <= y_prev - dy;
				z_q <= z_prev + angle;
			end else begin
				x_q <= x_prev - dx;
				y_q <= y_prev + dy;
				z_q <= z_prev - angle;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;

endmodule

// ===== src/aep_sincos.sv =====
// aep_sincos: quadrant fold, rotation-mode CORDIC row and sign restore.
// Each stage is registered. Depends on aep_pkg and aep_cordic_cell.

module aep_sincos
	import aep_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] theta,
	output logic signed [DW-1:0] cos_v,
	output logic signed [DW-1:0] sin_v
);

	logic signed [DW-1:0]    th_pre_q;
	logic                    flip_pre_q;
	logic [CORDIC_STEPS-1:0] flip_q;
	logic signed [DW-1:0]    xs [CORDIC_STEPS+1];
	logic signed [DW-1:0]    ys [CORDIC_STEPS+1];
	logic signed [DW-1:0]    zs [CORDIC_STEPS+1];
	logic signed [DW-1:0]    cos_q;
	logic signed [DW-1:0]    sin_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (theta > HALF_PI_Q) begin
				th_pre_q   <= theta - PI_Q;
				flip_pre_q <= 1'b1;
			end else if (theta < -HALF_PI_Q) begin
				th_pre_q   <= theta + PI_Q;
				flip_pre_q <= 1'b1;
			end else begin
				th_pre_q   <= theta;
				flip_pre_q <= 1'b0;
			end
			flip_q <= {flip_q[CORDIC_STEPS-2:0], flip_pre_q};
		end
	end

	assign xs[0] = GAIN_Q;
	assign ys[0] = '0;
	assign zs[0] = th_pre_q;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		localparam logic signed [DW-1:0] ATAN = atan_entry(i);
		aep_cordic_cell u_cell (
			.clk    (clk),
			.en     (en),
			.vect   (1'b0),
			.step   (STEP_W'(i)),
			.angle  (ATAN),
			.x_prev (xs[i]),
			.y_prev (ys[i]),
			.z_prev (zs[i]),
			.x      (xs[i+1]),
			.y      (ys[i+1]),
			.z      (zs[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= flip_q[CORDIC_STEPS-1] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
			sin_q <= flip_q[CORDIC_STEPS-1] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
		end
	end

	assign cos_v = cos_q;
	assign sin_v = sin_q;

endmodule

// ===== src/aep_vector.sv =====
// aep_vector: half-plane fold and vectoring-mode CORDIC row; gives gain-scaled
// magnitude and atan2; each stage is registered. Depends on aep_pkg, aep_cordic_cell.

module aep_vector
	import aep_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] vx,
	input  logic signed [DW-1:0] vy,
	output logic signed [DW-1:0] mag,
	output logic signed [DW-1:0] ang
);

	logic signed [DW-1:0] x_pre_q;
	logic signed [DW-1:0] y_pre_q;
	logic signed [DW-1:0] z_pre_q;
	logic signed [DW-1:0] xs [CORDIC_STEPS+1];
	logic signed [DW-1:0] ys [CORDIC_STEPS+1];
	logic signed [DW-1:0] zs [CORDIC_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (vx[DW-1]) begin
				x_pre_q <= -vx;
				y_pre_q <= -vy;
				z_pre_q <= vy[DW-1] ? -PI_Q : PI_Q;
			end else begin
				x_pre_q <= vx;
				y_pre_q <= vy;
				z_pre_q <= '0;
			end
		end
	end

	assign xs[0] = x_pre_q;
	assign ys[0] = y_pre_q;
	assign zs[0] = z_pre_q;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		localparam logic signed [DW-1:0] ATAN = atan_entry(i);
		aep_cordic_cell u_cell (
			.clk    (clk),
			.en     (en),
			.vect   (1'b1),
			.step   (STEP_W'(i)),
			.angle  (ATAN),
			.x_prev (xs[i]),
			.y_prev (ys[i]),
			.z_prev (zs[i]),
			.x      (xs[i+1]),
			.y      (ys[i+1]),
			.z      (zs[i+1])
		);
	end

	assign mag = xs[CORDIC_STEPS];
	assign ang = zs[CORDIC_STEPS];

endmodule

// ===== src/aep_mulq.sv =====
// aep_mulq: Q.32 product rounded half away from zero, two register stages.
// Depends on aep_pkg.

module aep_mulq
	import aep_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] a,
	input  logic signed [DW-1:0] b,
	output logic signed [DW-1:0] p
);

	logic signed [DW-1:0] a_abs;
	logic signed [DW-1:0] b_abs;
	logic [2*MW-1:0]      prod_s1;
	logic                 neg_s1;
	logic [DW-1:0]        rnd;
	logic signed [DW-1:0] p_s2;

	assign a_abs = a[DW-1] ? -a : a;
	assign b_abs = b[DW-1] ? -b : b;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= a_abs[MW-1:0] * b_abs[MW-1:0];
			neg_s1  <= a[DW-1] ^ b[DW-1];
		end
	end

	assign rnd = DW'(prod_s1[2*MW-1:32]) + DW'(prod_s1[31]);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= neg_s1 ? -$signed(rnd) : $signed(rnd);
		end
	end

	assign p = p_s2;

endmodule

// ===== src/azimuthal_equidistant_projection.sv =====
// Azimuthal equidistant projection: GPS fix to local north/east millimetres about a
// configured origin. Depends on aep_pkg, aep_sincos, aep_vector and aep_mulq.
//
// Usage: write the origin through the cfg port while no transaction is in flight,
// then stream fixes. One fix is taken per clock and one result comes back per fix,
// in order. The datapath is a fully pipelined row of CORDIC cells: three sine/cosine
// rows, a vectoring row for azimuth, then a vectoring row for the central angle in
// parallel with a sine/cosine row for the azimuth, and rounding Q.32 multipliers in
// between; three of the CORDIC rows lie in series from input to output. Throughput
// is one transaction per cycle; a two-entry output buffer lets input keep flowing
// while a result waits, and the pipeline only holds when both entries are full. Near
// the antipode the azimuth is lost: north is forced to +20015087000 mm, east to 0 and
// m_tuser is raised; any coordinate beyond that limit is clipped and flagged too.

module azimuthal_equidistant_projection
	import aep_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [31:0]       cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,   // [30:0] lat_e7, [62:31] lon_e7, [63] zero
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [71:0]       m_tdata,   // [35:0] north_mm, [71:36] east_mm
	output logic              m_tuser    // saturated
);

	localparam int N = CORDIC_STEPS;
	// stage index of the final clip register, counted from the input register
	localparam int L = 3 * N + 20;
	localparam logic signed [OW-1:0] LIM_O = OUT_LIM[OW-1:0];
	localparam int PW = 2 * OW + 1;

	// configuration
	logic signed [30:0] ref_lat_q;
	logic signed [31:0] ref_lon_q;

	// flow control
	logic         en;
	logic [L-1:0] vld_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	// front end
	logic signed [30:0] lat_in;
	logic signed [31:0] lon_in;
	logic signed [32:0] diff;
	logic signed [32:0] dwrap;
	logic signed [32:0] ang_s1 [3];
	logic signed [32:0] ang_abs [3];
	logic [63:0]        prod_s2 [3];
	logic [2:0]         neg_s2;
	logic [63:0]        rad_rnd [3];
	logic signed [DW-1:0] rad_mag [3];
	logic signed [DW-1:0] th_s3 [3];
	logic signed [DW-1:0] cosv [3];
	logic signed [DW-1:0] sinv [3];

	// spherical terms
	logic signed [DW-1:0] t_p;
	logic signed [DW-1:0] pss_p;
	logic signed [DW-1:0] pcs_p;
	logic signed [DW-1:0] eq_p;
	logic signed [DW-1:0] ct_p;
	logic signed [DW-1:0] st_p;
	logic signed [DW-1:0] cl0_dly_q [2];
	logic signed [DW-1:0] sl0_dly_q [2];
	logic signed [DW-1:0] pss_dly_q [2];
	logic signed [DW-1:0] pcs_dly_q [2];
	logic signed [DW-1:0] eq_dly_q [2];
	logic signed [DW-1:0] arg_sum;
	logic signed [DW-1:0] arg_s4;
	logic signed [DW-1:0] nq_s4;
	logic signed [DW-1:0] eq_s4;

	// azimuth and central angle
	logic signed [DW-1:0] m1;
	logic signed [DW-1:0] phi;
	logic signed [DW-1:0] s_p;
	logic signed [DW-1:0] arg_dly_q [N+3];
	logic signed [DW-1:0] phi_dly_q [2];
	logic [N+5:0]         zero_dly_q;
	logic [N+5:0]         aneg_dly_q;
	logic signed [DW-1:0] c_ang;
	logic signed [DW-1:0] c_dly_q;
	logic signed [DW-1:0] cp;
	logic signed [DW-1:0] sp;
	logic signed [DW-1:0] cn_p;
	logic signed [DW-1:0] ce_p;
	logic signed [DW-1:0] nr_p;
	logic signed [DW-1:0] er_p;

	// clip stage and output buffer
	logic signed [OW-1:0] north_s5;
	logic signed [OW-1:0] east_s5;
	logic                 sat_s5;
	logic [PW-1:0]        fin;
	logic [PW-1:0]        q0_q;
	logic [PW-1:0]        q1_q;
	logic signed [OW-1:0] m_north;
	logic signed [OW-1:0] m_east;

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= '0;
			ref_lon_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_REF_LAT: ref_lat_q <= cfg_wdata[30:0];
				REG_REF_LON: ref_lon_q <= cfg_wdata;
			endcase
		end
	end

	// ---------------------------------------------------------------- flow control
	// Whole pipeline moves together; it holds only when the output buffer is full.
	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;
	assign push     = en & vld_q[L-1];
	assign pop      = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], s_tvalid};
		end
	end

	// ---------------------------------------------------------------- stage 1: wrap
	assign lat_in = s_tdata[30:0];
	assign lon_in = s_tdata[62:31];
	assign diff   = {lon_in[31], lon_in} - {ref_lon_q[31], ref_lon_q};

	always_comb begin
		if (diff >= HALF_TURN_E7) begin
			dwrap = diff - FULL_TURN_E7;
		end else if (diff < -HALF_TURN_E7) begin
			dwrap = diff + FULL_TURN_E7;
		end else begin
			dwrap = diff;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1[0] <= {{2{ref_lat_q[30]}}, ref_lat_q};
			ang_s1[1] <= {{2{lat_in[30]}}, lat_in};
			ang_s1[2] <= dwrap;
		end
	end

	// ---------------------------------------------------------------- stages 2-3: to radians
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			ang_abs[j] = ang_s1[j][32] ? -ang_s1[j] : ang_s1[j];
			rad_rnd[j] = prod_s2[j] + 64'd268435456;
			rad_mag[j] = {{(DW-35){1'b0}}, rad_rnd[j][63:29]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				prod_s2[j] <= ang_abs[j][31:0] * DEG_COEF;
				neg_s2[j]  <= ang_s1[j][32];
				th_s3[j]   <= neg_s2[j] ? -rad_mag[j] : rad_mag[j];
			end
		end
	end

	// origin latitude, fix latitude, longitude difference
	for (genvar j = 0; j < 3; j++) begin : g_sc
		aep_sincos u_sincos (
			.clk   (clk),
			.en    (en),
			.theta (th_s3[j]),
			.cos_v (cosv[j]),
			.sin_v (sinv[j])
		);
	end

	// ---------------------------------------------------------------- spherical terms
	aep_mulq u_mul_t   (.clk(clk), .en(en), .a(cosv[1]), .b(cosv[2]), .p(t_p));
	aep_mulq u_mul_ss  (.clk(clk), .en(en), .a(sinv[0]), .b(sinv[1]), .p(pss_p));
	aep_mulq u_mul_cs  (.clk(clk), .en(en), .a(cosv[0]), .b(sinv[1]), .p(pcs_p));
	aep_mulq u_mul_e   (.clk(clk), .en(en), .a(cosv[1]), .b(sinv[2]), .p(eq_p));
	aep_mulq u_mul_ct  (.clk(clk), .en(en), .a(cl0_dly_q[1]), .b(t_p), .p(ct_p));
	aep_mulq u_mul_st  (.clk(clk), .en(en), .a(sl0_dly_q[1]), .b(t_p), .p(st_p));

	always_ff @(posedge clk) begin
		if (en) begin
			cl0_dly_q[0] <= cosv[0];
			cl0_dly_q[1] <= cl0_dly_q[0];
			sl0_dly_q[0] <= sinv[0];
			sl0_dly_q[1] <= sl0_dly_q[0];
			pss_dly_q[0] <= pss_p;
			pss_dly_q[1] <= pss_dly_q[0];
			pcs_dly_q[0] <= pcs_p;
			pcs_dly_q[1] <= pcs_dly_q[0];
			eq_dly_q[0]  <= eq_p;
			eq_dly_q[1]  <= eq_dly_q[0];
		end
	end

	// cosine of the central angle, clamped to the unit range
	assign arg_sum = pss_dly_q[1] + ct_p;

	always_ff @(posedge clk) begin
		if (en) begin
			if (arg_sum > ONE_Q) begin
				arg_s4 <= ONE_Q;
			end else if (arg_sum < -ONE_Q) begin
				arg_s4 <= -ONE_Q;
			end else begin
				arg_s4 <= arg_sum;
			end
			nq_s4 <= pcs_dly_q[1] - st_p;
			eq_s4 <= eq_dly_q[1];
		end
	end

	// ---------------------------------------------------------------- azimuth
	aep_vector u_vec_dir (
		.clk (clk),
		.en  (en),
		.vx  (nq_s4),
		.vy  (eq_s4),
		.mag (m1),
		.ang (phi)
	);

	aep_mulq u_mul_gain (.clk(clk), .en(en), .a(m1), .b(GAIN_Q), .p(s_p));

	always_ff @(posedge clk) begin
		if (en) begin
			arg_dly_q[0] <= arg_s4;
			for (int k = 1; k < N + 3; k++) begin
				arg_dly_q[k] <= arg_dly_q[k-1];
			end
			phi_dly_q[0] <= phi;
			phi_dly_q[1] <= phi_dly_q[0];
			// coincident or antipodal point: no direction left
			zero_dly_q   <= {zero_dly_q[N+4:0], (s_p == '0)};
			aneg_dly_q   <= {aneg_dly_q[N+4:0], arg_dly_q[N+2][DW-1]};
			c_dly_q      <= c_ang;
		end
	end

	// ---------------------------------------------------------------- central angle
	aep_vector u_vec_ang (
		.clk (clk),
		.en  (en),
		.vx  (arg_dly_q[N+2]),
		.vy  (s_p),
		.mag (),
		.ang (c_ang)
	);

	aep_sincos u_sc_az (
		.clk   (clk),
		.en    (en),
		.theta (phi_dly_q[1]),
		.cos_v (cp),
		.sin_v (sp)
	);

	aep_mulq u_mul_cn (.clk(clk), .en(en), .a(c_dly_q), .b(cp), .p(cn_p));
	aep_mulq u_mul_ce (.clk(clk), .en(en), .a(c_dly_q), .b(sp), .p(ce_p));
	aep_mulq u_mul_rn (.clk(clk), .en(en), .a(cn_p), .b(RADIUS_MM), .p(nr_p));
	aep_mulq u_mul_re (.clk(clk), .en(en), .a(ce_p), .b(RADIUS_MM), .p(er_p));

	// ---------------------------------------------------------------- clip
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_dly_q[N+5]) begin
				north_s5 <= aneg_dly_q[N+5] ? LIM_O : '0;
				east_s5  <= '0;
				sat_s5   <= aneg_dly_q[N+5];
			end else begin
				sat_s5 <= (nr_p > OUT_LIM) || (nr_p < -OUT_LIM) ||
					(er_p > OUT_LIM) || (er_p < -OUT_LIM);
				if (nr_p > OUT_LIM) begin
					north_s5 <= LIM_O;
				end else if (nr_p < -OUT_LIM) begin
					north_s5 <= -LIM_O;
				end else begin
					north_s5 <= nr_p[OW-1:0];
				end
				if (er_p > OUT_LIM) begin
					east_s5 <= LIM_O;
				end else if (er_p < -OUT_LIM) begin
					east_s5 <= -LIM_O;
				end else begin
					east_s5 <= er_p[OW-1:0];
				end
			end
		end
	end

	// ---------------------------------------------------------------- output buffer
	assign fin = {sat_s5, east_s5, north_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					q0_q <= fin;
				end else begin
					q1_q <= fin;
				end
			end
			2'b01: q0_q <= q1_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					q0_q <= fin;
				end else begin
					q0_q <= q1_q;
					q1_q <= fin;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_north  = q0_q[OW-1:0];
	assign m_east   = q0_q[2*OW-1:OW];
	assign m_tdata  = {m_east, m_north};
	assign m_tuser  = q0_q[2*OW];

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_north == LIM_O) || (m_north == -LIM_O) ||
			(m_east == LIM_O) || (m_east == -LIM_O))
		else $error("saturated result with no coordinate at the limit");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while output buffer full");

	a_full_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) && !pop |=> (cnt_q == 2'd2))
		else $error("full output buffer lost an entry without a pop");
`endif

endmodule

// ===== tb/tb_azimuthal_equidistant_projection.sv =====
// Self-checking testbench for azimuthal_equidistant_projection: streams GPS fixes under
// several origins and checks every projected result against a bit-exact predictor.
// Depends on aep_pkg (register indexes, port widths) and the block itself.

module tb_azimuthal_equidistant_projection;
	import aep_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// constants of the projection: angles, one and the CORDIC gain in Q.32, then scale factors
	localparam int STEPS = CORDIC_STEPS;
	localparam longint unsigned PI_60B = 64'h3243F6A8885A308D;
	localparam longint PI_Q32 = longint'((PI_60B + 64'd134217728) >> 28);
	localparam longint HALF_PI_Q32 = longint'((PI_60B + 64'd268435456) >> 29);
	localparam longint ONE_Q32 = 64'sd1 << 32;
	localparam longint K_GAIN = 64'sh9B74EDA8;
	localparam longint unsigned E7_TO_RAD = (64'd2 * PI_60B + 64'd900000000) / 64'd1800000000;
	localparam longint HALF_TURN = 64'sd1800000000;
	localparam longint EARTH_MM = 64'sd6371000000;
	localparam longint CLIP_MM = 64'sd20015087000;

	typedef enum logic [1:0] {FIX_ITEM, REG_WRITE, DRAIN_WAIT} step_kind_t;

	typedef struct {
		step_kind_t kind;
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic [CFG_AW-1:0] addr;
		logic [31:0] wdata;
		int gap;
	} step_t;

	typedef struct {
		logic [35:0] north;
		logic [35:0] east;
		logic sat;
	} plane_pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;    // [30:0] lat_e7, [62:31] lon_e7, [63] zero
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [71:0] m_tdata;         // [35:0] north_mm, [71:36] east_mm
	logic m_tuser;                // saturated

	azimuthal_equidistant_projection dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	step_t pending[$];
	plane_pt_t expected_pts[$];
	longint atan_q[STEPS];
	logic signed [30:0] origin_lat = '0;   // predictor's copy of the origin registers
	logic signed [31:0] origin_lon = '0;
	int n_in = 0;        // accepted fix transactions
	int n_sent = 0;      // fixes offered by the driver
	int n_out = 0;       // accepted result transactions
	int errors = 0;

	// ---------------- predictor ----------------

	function automatic longint mul_q32(longint a, longint b);
		bit neg;
		longint unsigned ua, ub, ah, al, bh, bl, ll, r;
		longint s;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		ah = ua >> 32;
		al = ua & 64'hFFFFFFFF;
		bh = ub >> 32;
		bl = ub & 64'hFFFFFFFF;
		ll = al * bl;
		r = ((ah * bh) << 32) + ah * bl + al * bh + (ll >> 32) + ((ll >> 31) & 64'd1);
		s = longint'(r & 64'h3FFFFFFFFFFFFFFF);
		return neg ? -s : s;
	endfunction

	function automatic longint e7_to_rad(longint v);
		longint unsigned u;
		longint r;
		u = (v < 0) ? -v : v;
		r = longint'((u * E7_TO_RAD + 64'd268435456) >> 29);
		return (v < 0) ? -r : r;
	endfunction

	// rotation mode: cosine and sine of a Q.32 angle
	task automatic rotate_q32(input longint th, output longint c, output longint s);
		bit flip;
		longint x, y, dx, dy;
		flip = 1'b0;
		if (th > HALF_PI_Q32) begin
			th -= PI_Q32;
			flip = 1'b1;
		end else if (th < -HALF_PI_Q32) begin
			th += PI_Q32;
			flip = 1'b1;
		end
		x = K_GAIN;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (th >= 0) begin
				x -= dx; y += dy; th -= atan_q[i];
			end else begin
				x += dx; y -= dy; th += atan_q[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// vectoring mode: gain-scaled magnitude and atan2(y, x)
	task automatic vector_q32(input longint x, input longint y, output longint mag,
			output longint ang);
		longint z, dx, dy;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_Q32 : -PI_Q32;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_q[i];
			end else begin
				x -= dx; y += dy; z -= atan_q[i];
			end
		end
		mag = x;
		ang = z;
	endtask

	task automatic project_fix(input logic signed [30:0] lat, input logic signed [31:0] lon,
			output plane_pt_t pt);
		longint d, cl0, sl0, cl, sl, cd, sd, t, cos_c, nq, eq, m, az, s;
		longint m2, c, cp, sp, north, east;
		logic sat;
		d = longint'(lon) - longint'(origin_lon);
		if (d >= HALF_TURN)
			d -= 2 * HALF_TURN;
		else if (d < -HALF_TURN)
			d += 2 * HALF_TURN;
		rotate_q32(e7_to_rad(longint'(origin_lat)), cl0, sl0);
		rotate_q32(e7_to_rad(longint'(lat)), cl, sl);
		rotate_q32(e7_to_rad(d), cd, sd);
		t = mul_q32(cl, cd);
		cos_c = mul_q32(sl0, sl) + mul_q32(cl0, t);
		if (cos_c > ONE_Q32)
			cos_c = ONE_Q32;
		else if (cos_c < -ONE_Q32)
			cos_c = -ONE_Q32;
		nq = mul_q32(cl0, sl) - mul_q32(sl0, t);
		eq = mul_q32(cl, sd);
		vector_q32(nq, eq, m, az);
		s = mul_q32(m, K_GAIN);
		north = 0;
		east = 0;
		sat = 1'b0;
		if (s == 0) begin
			// no direction left: coincident, or antipode with the azimuth lost
			if (cos_c < 0) begin
				north = CLIP_MM;
				sat = 1'b1;
			end
		end else begin
			vector_q32(cos_c, s, m2, c);
			rotate_q32(az, cp, sp);
			north = mul_q32(mul_q32(c, cp), EARTH_MM);
			east = mul_q32(mul_q32(c, sp), EARTH_MM);
			if (north > CLIP_MM) begin north = CLIP_MM; sat = 1'b1; end
			if (north < -CLIP_MM) begin north = -CLIP_MM; sat = 1'b1; end
			if (east > CLIP_MM) begin east = CLIP_MM; sat = 1'b1; end
			if (east < -CLIP_MM) begin east = -CLIP_MM; sat = 1'b1; end
		end
		pt.north = north[35:0];
		pt.east = east[35:0];
		pt.sat = sat;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("[%0t] mismatch on result %0d: %s got %0h want %0h", $realtime, n_out, what,
			got, want);
		errors++;
	endtask

	// ---------------- driver ----------------
	// Drives on the falling edge; a raised fix stays up until the monitor counts it.
	int fix_gap = 0;

	always @(negedge clk) begin
		logic v, w;
		v = s_tvalid;
		w = 1'b0;
		if (arst_n) begin
			if (v && n_in == n_sent)
				v = 1'b0;
			if (!v) begin
				if (fix_gap > 0) begin
					fix_gap--;
				end else if (pending.size() > 0) begin
					case (pending[0].kind)
						FIX_ITEM: begin
							s_tdata <= {1'b0, pending[0].lon, pending[0].lat};
							v = 1'b1;
							n_sent++;
							fix_gap = pending[0].gap;
							void'(pending.pop_front());
						end
						REG_WRITE: begin
							// origin changes only with the pipeline empty
							if (expected_pts.size() == 0 && n_in == n_sent) begin
								cfg_addr <= pending[0].addr;
								cfg_wdata <= pending[0].wdata;
								w = 1'b1;
								void'(pending.pop_front());
							end
						end
						DRAIN_WAIT: begin
							if (expected_pts.size() == 0 && n_in == n_sent)
								void'(pending.pop_front());
						end
						default: void'(pending.pop_front());
					endcase
				end
			end
		end
		s_tvalid <= v;
		cfg_wr_en <= w;
	end

	// ---------------- receiver ----------------
	// Per-result stalls, quiet stretches every other 256 results, and one long hold-off
	// once 200 fixes are in so the output buffer fills and s_tready drops.
	int rx_stall = 0;
	int rx_seen = 0;
	int hold_left = 0;
	bit held = 1'b0;

	always @(negedge clk) begin
		logic r;
		r = 1'b0;
		if (arst_n) begin
			if (n_out != rx_seen) begin
				rx_seen = n_out;
				rx_stall = (n_out[8] || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
			end
			if (hold_left > 0) begin
				hold_left--;
			end else if (!held && n_in >= 200) begin
				held = 1'b1;
				hold_left = 400;
			end else if (rx_stall > 0) begin
				rx_stall--;
			end else begin
				r = 1'b1;
			end
		end
		m_tready <= r;
	end

	// ---------------- monitor and checker ----------------

	always @(posedge clk) begin
		plane_pt_t pt;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_REF_LAT: origin_lat = cfg_wdata[30:0];
					REG_REF_LON: origin_lon = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				project_fix(s_tdata[30:0], s_tdata[62:31], pt);
				expected_pts = {expected_pts, pt};
				n_in <= n_in + 1;
			end
			if (m_tvalid && m_tready) begin
				if (expected_pts.size() == 0) begin
					$display("[%0t] result transaction with nothing expected", $realtime);
					errors++;
				end else begin
					pt = expected_pts.pop_front();
					if (m_tdata[35:0] !== pt.north)
						report_mismatch("north_mm", m_tdata[35:0], pt.north);
					if (m_tdata[71:36] !== pt.east)
						report_mismatch("east_mm", m_tdata[71:36], pt.east);
					if (m_tuser !== pt.sat)
						report_mismatch("saturated", m_tuser, pt.sat);
				end
				n_out <= n_out + 1;
			end
		end
	end

	// ---------------- stimulus ----------------

	logic signed [30:0] plan_lat = '0;
	logic signed [31:0] plan_lon = '0;
	bit calm = 1'b0;

	task automatic add_fix(input longint lat, input longint lon);
		step_t st;
		st.kind = FIX_ITEM;
		st.lat = lat[30:0];
		st.lon = lon[31:0];
		st.addr = '0;
		st.wdata = '0;
		st.gap = (calm || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 14);
		pending = {pending, st};
	endtask

	task automatic set_origin(input longint lat, input longint lon);
		step_t st;
		st.kind = REG_WRITE;
		st.lat = '0;
		st.lon = '0;
		st.gap = 0;
		st.addr = REG_REF_LAT;
		st.wdata = 32'(lat);
		pending = {pending, st};
		st.addr = REG_REF_LON;
		st.wdata = 32'(lon);
		pending = {pending, st};
		plan_lat = lat[30:0];
		plan_lon = lon[31:0];
	endtask

	task automatic add_drain();
		step_t st;
		st.kind = DRAIN_WAIT;
		st.lat = '0;
		st.lon = '0;
		st.addr = '0;
		st.wdata = '0;
		st.gap = 0;
		pending = {pending, st};
	endtask

	// the antipode of the planned origin, with a small offset
	task automatic add_antipode(input longint jitter);
		longint lon;
		lon = longint'(plan_lon) + HALF_TURN;
		if (lon >= HALF_TURN)
			lon -= 2 * HALF_TURN;
		add_fix(-longint'(plan_lat) + jitter, lon - jitter);
	endtask

	task automatic add_random_fix();
		longint j1, j2;
		j1 = longint'($urandom_range(0, 4000)) - 2000;
		j2 = longint'($urandom_range(0, 4000)) - 2000;
		case ($urandom_range(0, 9))
			0: add_fix(longint'($signed($urandom() & 32'h7FFFFFFF) <<< 1) >>> 1,
				longint'($signed($urandom())));
			1: add_fix(longint'(plan_lat) + j1, longint'(plan_lon) + j2);
			2: add_antipode(($urandom_range(0, 3) == 0) ? 0 : j1);
			default: add_fix(longint'($urandom_range(0, 1800000000)) - 900000000,
				longint'($urandom_range(0, 32'd3600000000)) - HALF_TURN);
		endcase
	endtask

	initial begin
		longint unsigned v;
		longint t;
		int e;
		// arctangent table, alternating series at 60 fraction bits
		for (int i = 0; i < STEPS; i++) begin
			if (i == 0) begin
				atan_q[i] = longint'(((PI_60B >> 2) + 64'd134217728) >> 28);
			end else begin
				v = 0;
				for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
					e = i * (2 * k + 1);
					t = longint'((64'd1 << (60 - e)) / (2 * k + 1));
					v = (k % 2) ? v - t : v + t;
				end
				atan_q[i] = longint'((v + 64'd134217728) >> 28);
			end
		end

		// directed: origin at reset value
		add_fix(0, 0);
		add_fix(0, HALF_TURN);
		add_fix(0, -HALF_TURN);
		add_fix(900000000, 0);
		add_fix(-900000000, 0);
		add_fix(-900000000, 1800000000);
		add_fix(1, 0);
		add_fix(0, 1);
		add_fix(0, -1);
		add_fix(-(64'sd1 << 30), -(64'sd1 << 31));
		add_fix((64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
		add_fix(450000000, -900000000);
		add_drain();

		// phases over origins: range corners, bit-range corners, the zero origin, then random
		for (int p = 0; p < 10; p++) begin
			calm = (p % 3 == 1);
			case (p)
				0: set_origin(900000000, 1800000000);
				1: set_origin(-900000000, -1800000000);
				2: set_origin(-(64'sd1 << 30), -(64'sd1 << 31));
				3: set_origin((64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
				4: set_origin(0, 0);
				default: set_origin(longint'($urandom_range(0, 1800000000)) - 900000000,
					longint'($urandom_range(0, 32'd3600000000)) - HALF_TURN);
			endcase
			add_fix(plan_lat, plan_lon);
			add_antipode(0);
			add_fix(-longint'(plan_lat), plan_lon);
			for (int n = 0; n < 132; n++) begin
				add_random_fix();
				if (n == 66 && p % 2 == 0)
					add_drain();
			end
			add_drain();
		end

		repeat (2) @(posedge clk);
		arst_n = 1'b1;

		while (pending.size() > 0 || s_tvalid || expected_pts.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (expected_pts.size() > 0) begin
			$display("%0d expected results never arrived", expected_pts.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_azimuthal_equidistant_projection: PASS");
		else
			$display("tb_azimuthal_equidistant_projection: FAIL");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#4ms;
		$display("tb_azimuthal_equidistant_projection: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/aep_pkg.sv
src/aep_cordic_cell.sv
src/aep_sincos.sv
src/aep_vector.sv
src/aep_mulq.sv
src/azimuthal_equidistant_projection.sv
tb/tb_azimuthal_equidistant_projection.sv
